>>> rtl/fp16_matrix_multiply_macros.svh
// assertion macros for the fp16 matrix multiply checker
`ifndef FP16_MATRIX_MULTIPLY_MACROS_SVH
`define FP16_MATRIX_MULTIPLY_MACROS_SVH

// property checked only outside reset
`define FP16MM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define FP16MM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/fp16mm_pkg.sv
// types, codes and binary16 arithmetic helpers for the fp16 matrix multiply
`default_nettype none
package fp16mm_pkg;

  localparam int MAX_DIM_DEFAULT = 16;
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

  localparam logic [1:0] MODE_WR_A = 2'd0;
  localparam logic [1:0] MODE_WR_B = 2'd1;
  localparam logic [1:0] MODE_COMP = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHAPE = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] CFG_A_ROWS = 2'd0;
  localparam logic [1:0] CFG_A_COLS = 2'd1;
  localparam logic [1:0] CFG_B_ROWS = 2'd2;
  localparam logic [1:0] CFG_B_COLS = 2'd3;

  localparam logic [15:0] HALF_QNAN = 16'h7E00;
  localparam logic [14:0] HALF_INF  = 15'h7C00;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  row_index;
    logic [3:0]  col_index;
    logic [15:0] element_value;
  } in_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic [1:0]  status;
  } out_t;

  // control that travels with a pair of operands into the mac
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  // exact intermediate: value = mag * 2^ex, or a special pattern
  typedef struct packed {
    logic              special;
    logic [15:0]       spec_val;
    logic              sign;
    logic [47:0]       mag;
    logic signed [7:0] ex;
  } exact_t;

  function automatic exact_t fp16_mul_exact(input logic [15:0] a, input logic [15:0] b);
    exact_t r;
    logic [4:0] ea, eb;
    logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [10:0] sa, sb;
    int ee;
    ea = a[14:10];
    eb = b[14:10];
    nan_a  = (ea == 5'd31) && (a[9:0] != 10'd0);
    nan_b  = (eb == 5'd31) && (b[9:0] != 10'd0);
    inf_a  = (ea == 5'd31) && (a[9:0] == 10'd0);
    inf_b  = (eb == 5'd31) && (b[9:0] == 10'd0);
    zero_a = (a[14:0] == 15'd0);
    zero_b = (b[14:0] == 15'd0);
    sa = {ea != 5'd0, a[9:0]};
    sb = {eb != 5'd0, b[9:0]};
    ee = ((ea == 5'd0) ? 1 : int'(ea)) + ((eb == 5'd0) ? 1 : int'(eb)) - 50;
    r.sign = a[15] ^ b[15];
    r.mag = {26'd0, 22'(sa * sb)};
    r.ex = 8'(ee);
    r.special = 1'b0;
    r.spec_val = 16'd0;
    if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
      r.special = 1'b1;
      r.spec_val = HALF_QNAN;
    end else if (inf_a || inf_b) begin
      r.special = 1'b1;
      r.spec_val = {r.sign, HALF_INF};
    end
    return r;
  endfunction

  function automatic exact_t fp16_add_align(input logic [15:0] a, input logic [15:0] b);
    exact_t r;
    logic [4:0] ea, eb, da, db, d;
    logic nan_a, nan_b, inf_a, inf_b;
    logic [47:0] big, sml;
    logic s_big, s_sml;
    ea = a[14:10];
    eb = b[14:10];
    nan_a = (ea == 5'd31) && (a[9:0] != 10'd0);
    nan_b = (eb == 5'd31) && (b[9:0] != 10'd0);
    inf_a = (ea == 5'd31) && (a[9:0] == 10'd0);
    inf_b = (eb == 5'd31) && (b[9:0] == 10'd0);
    da = (ea == 5'd0) ? 5'd1 : ea;
    db = (eb == 5'd0) ? 5'd1 : eb;
    if (da >= db) begin
      d = da - db;
      big = 48'({ea != 5'd0, a[9:0]}) << d;
      sml = 48'({eb != 5'd0, b[9:0]});
      s_big = a[15];
      s_sml = b[15];
      r.ex = 8'(int'(db) - 25);
    end else begin
      d = db - da;
      big = 48'({eb != 5'd0, b[9:0]}) << d;
      sml = 48'({ea != 5'd0, a[9:0]});
      s_big = b[15];
      s_sml = a[15];
      r.ex = 8'(int'(da) - 25);
    end
    if (s_big == s_sml) begin
      r.mag = big + sml;
      r.sign = s_big;
    end else if (big >= sml) begin
      r.mag = big - sml;
      r.sign = s_big;
    end else begin
      r.mag = sml - big;
      r.sign = s_sml;
    end
    // exact cancellation gives +0 unless both operands are negative
    if (r.mag == 48'd0) begin
      r.sign = a[15] & b[15];
    end
    r.special = 1'b0;
    r.spec_val = 16'd0;
    if (nan_a || nan_b || (inf_a && inf_b && (a[15] != b[15]))) begin
      r.special = 1'b1;
      r.spec_val = HALF_QNAN;
    end else if (inf_a) begin
      r.special = 1'b1;
      r.spec_val = a;
    end else if (inf_b) begin
      r.special = 1'b1;
      r.spec_val = b;
    end
    return r;
  endfunction

  // round an exact value to binary16, nearest even
  function automatic logic [15:0] fp16_round(input exact_t x);
    logic [63:0] m, q, rem, half;
    logic [15:0] r;
    int p, sh, ue, o;
    m = 64'(x.mag);
    p = 0;
    q = 64'd0;
    for (int i = 0; i < 48; i++) begin
      if (m[i]) begin
        p = i;
      end
    end
    ue = p + int'(x.ex);
    sh = p - 10;
    if (-24 - int'(x.ex) > sh) begin
      sh = -24 - int'(x.ex);
    end
    if (sh <= 0) begin
      q = m << (-sh);
    end else if (sh < 60) begin
      q = m >> sh;
      rem = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if ((rem > half) || ((rem == half) && q[0])) begin
        q = q + 64'd1;
      end
    end
    o = ((ue >= -14) ? ((ue + 14) << 10) : 0) + int'(q[15:0]);
    if (o >= 32'h7C00) begin
      o = 32'h7C00;
    end
    r = {x.sign, o[14:0]};
    if (x.special) begin
      r = x.spec_val;
    end else if (x.mag == 48'd0) begin
      r = {x.sign, 15'd0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/fp16mm_mac.sv
// binary16 multiply-accumulate pipeline, rounding after each operation
`default_nettype none
module fp16mm_mac (
  input  wire                   clk,
  input  wire                   rst,
  input  fp16mm_pkg::mac_ctl_t  ctl,
  input  wire  [15:0]           a_data,
  input  wire  [15:0]           b_data,
  output logic                  done,
  output logic [15:0]           acc
);

  fp16mm_pkg::mac_ctl_t ctl_mul, ctl_prd;
  logic                 aln_valid, aln_last;
  fp16mm_pkg::exact_t   mul_x, aln_x;
  logic [15:0]          prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mul   <= '0;
      ctl_prd   <= '0;
      aln_valid <= 1'b0;
      aln_last  <= 1'b0;
      done      <= 1'b0;
    end else begin
      ctl_mul   <= ctl;
      ctl_prd   <= ctl_mul;
      aln_valid <= ctl_prd.valid && !ctl_prd.first;
      aln_last  <= ctl_prd.last;
      done      <= (ctl_prd.valid && ctl_prd.first && ctl_prd.last) ||
                   (aln_valid && aln_last);
    end
  end

  always_ff @(posedge clk) begin
    mul_x <= fp16mm_pkg::fp16_mul_exact(a_data, b_data);
    prod  <= fp16mm_pkg::fp16_round(mul_x);
    if (ctl_prd.valid && !ctl_prd.first) begin
      aln_x <= fp16mm_pkg::fp16_add_align(acc, prod);
    end
    // first product seeds the sum, later ones are added in order
    if (ctl_prd.valid && ctl_prd.first) begin
      acc <= prod;
    end else if (aln_valid) begin
      acc <= fp16mm_pkg::fp16_round(aln_x);
    end
  end

endmodule
`default_nettype wire

>>> rtl/fp16_matrix_multiply.sv
// top level of the fp16 matrix multiply: element stores, sequencer, result register
// a write or a rejected request answers in the cycle after its transaction
// a compute issues a read pair only while phase is low, because the rounded add
// feeds the accumulator back through the aln_x and acc registers
// one item at a time; a new item is taken once the result register is free or drains
// rst clears control and the dimension registers (all 16); stores are not cleared
`default_nettype none
module fp16_matrix_multiply #(
  parameter int MAX_DIM = fp16mm_pkg::MAX_DIM_DEFAULT
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  fp16mm_pkg::in_t                in_data,
  output logic                           out_valid,
  input  wire                            out_ready,
  output fp16mm_pkg::out_t               out_data,
  input  wire                            cfg_we,
  input  wire  [1:0]                     cfg_index,
  input  wire  [fp16mm_pkg::CFG_W-1:0]   cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // element stores, one synchronous read port each
  logic [15:0] a_mem [DEPTH];
  logic [15:0] b_mem [DEPTH];
  logic [15:0] a_q, b_q;

  logic [fp16mm_pkg::CFG_W-1:0] a_rows, a_cols, b_rows, b_cols;
  logic [1:0]                   state;
  logic [3:0]                   req_row, req_col;
  logic [fp16mm_pkg::CFG_W-1:0] k;
  logic                         phase;

  logic                 accept, issue, out_free;
  logic                 wr_in_range, dims_ok, idx_ok;
  logic [AW-1:0]        wr_addr, rd_addr_a, rd_addr_b;
  fp16mm_pkg::mac_ctl_t rd_ctl;
  logic                 mac_done;
  logic [15:0]          mac_acc;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // request checks
  assign wr_in_range = (32'(in_data.row_index) < MAX_DIM) && (32'(in_data.col_index) < MAX_DIM);
  assign dims_ok = (a_rows != '0) && (32'(a_rows) <= MAX_DIM) &&
                   (a_cols != '0) && (32'(a_cols) <= MAX_DIM) &&
                   (b_cols != '0) && (32'(b_cols) <= MAX_DIM);
  assign idx_ok  = (5'(in_data.row_index) < a_rows) && (5'(in_data.col_index) < b_cols);

  // store addresses are row * MAX_DIM + col
  assign wr_addr   = AW'(32'(in_data.row_index) * MAX_DIM + 32'(in_data.col_index));
  assign rd_addr_a = AW'(32'(req_row) * MAX_DIM + 32'(k));
  assign rd_addr_b = AW'(32'(k) * MAX_DIM + 32'(req_col));

  // one read pair while phase is low and inner products remain
  assign issue = (state == S_RUN) && !phase && (k < a_cols);

  always_ff @(posedge clk) begin
    if (accept && wr_in_range && (in_data.mode == fp16mm_pkg::MODE_WR_A)) begin
      a_mem[wr_addr] <= in_data.element_value;
    end
    if (accept && wr_in_range && (in_data.mode == fp16mm_pkg::MODE_WR_B)) begin
      b_mem[wr_addr] <= in_data.element_value;
    end
    a_q <= a_mem[rd_addr_a];
    b_q <= b_mem[rd_addr_b];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= fp16mm_pkg::DIM_RESET;
      a_cols <= fp16mm_pkg::DIM_RESET;
      b_rows <= fp16mm_pkg::DIM_RESET;
      b_cols <= fp16mm_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fp16mm_pkg::CFG_A_ROWS: a_rows <= cfg_data;
        fp16mm_pkg::CFG_A_COLS: a_cols <= cfg_data;
        fp16mm_pkg::CFG_B_ROWS: b_rows <= cfg_data;
        fp16mm_pkg::CFG_B_COLS: b_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_ctl    <= '0;
      k         <= '0;
      phase     <= 1'b0;
    end else begin
      rd_ctl.valid <= issue;
      rd_ctl.first <= (k == '0);
      rd_ctl.last  <= (k == a_cols - 5'd1);
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            out_data.result_value <= 16'd0;
            out_data.status       <= fp16mm_pkg::ST_OK;
            out_valid             <= 1'b1;
            case (in_data.mode)
              fp16mm_pkg::MODE_WR_A, fp16mm_pkg::MODE_WR_B: begin
                if (!wr_in_range) begin
                  out_data.status <= fp16mm_pkg::ST_RANGE;
                end
              end
              fp16mm_pkg::MODE_COMP: begin
                if (a_cols != b_rows) begin
                  out_data.status <= fp16mm_pkg::ST_SHAPE;
                end else if (!dims_ok || !idx_ok) begin
                  out_data.status <= fp16mm_pkg::ST_RANGE;
                end else begin
                  // valid request: no answer until the sum is done
                  out_valid <= 1'b0;
                  req_row   <= in_data.row_index;
                  req_col   <= in_data.col_index;
                  k         <= '0;
                  phase     <= 1'b0;
                  state     <= S_RUN;
                end
              end
              default: out_data.status <= fp16mm_pkg::ST_RANGE;
            endcase
          end
        end
        S_RUN: begin
          phase <= !phase;
          if (issue) begin
            k <= k + 5'd1;
          end
          if (mac_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold the sum until the result register frees up
          if (out_free) begin
            out_data.result_value <= mac_acc;
            out_data.status       <= fp16mm_pkg::ST_OK;
            out_valid             <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  fp16mm_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (rd_ctl),
    .a_data (a_q),
    .b_data (b_q),
    .done   (mac_done),
    .acc    (mac_acc)
  );

endmodule
`default_nettype wire

>>> rtl/fp16mm_checker.sv
// port-level checks for the fp16 matrix multiply, bound to the top level
`default_nettype none
`include "fp16_matrix_multiply_macros.svh"
module fp16mm_checker (
  input wire                clk,
  input wire                rst,
  input wire                in_ready,
  input wire                out_valid,
  input wire                out_ready,
  input fp16mm_pkg::out_t   out_data
);

  // result stays offered until taken
  `FP16MM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result dropped or changed while stalled")

  // a result waiting on a stalled consumer blocks new transactions
  `FP16MM_ASSERT(a_no_take_when_full, out_valid && !out_ready |-> !in_ready, "input taken while result register is full")

  // any error answer carries a zero value
  `FP16MM_ASSERT(a_err_zero, out_valid && (out_data.status != fp16mm_pkg::ST_OK) |-> out_data.result_value == 16'd0, "error result with nonzero value")

  // nothing is offered right after reset
  `FP16MM_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

endmodule

bind fp16_matrix_multiply fp16mm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

>>> tb/fp16_matrix_multiply_test.sv
// self-checking testbench for the fp16 matrix multiply: stores, dot products, status codes
`timescale 1ns / 1ps
`default_nettype none
module fp16_matrix_multiply_test;
  import fp16mm_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int DIM = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_A_ROWS;
  logic [CFG_W-1:0] cfg_data = '0;

  fp16_matrix_multiply dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // shadow copy of the element stores and dimension registers
  logic [15:0] a_elems [DIM*DIM];
  logic [15:0] b_elems [DIM*DIM];
  logic [4:0] a_rows_q = 5'd16, a_cols_q = 5'd16, b_rows_q = 5'd16, b_cols_q = 5'd16;

  out_t c_elems_due [$];
  int fails = 0;
  int cycles = 0;
  int items_sent = 0;
  bit quiet = 1'b0;

  // ---------------------------------------------------------------
  // binary16 arithmetic, exact intermediate then one rounding
  // ---------------------------------------------------------------
  function automatic bit half_nan(logic [15:0] h);
    return h[14:10] == 5'd31 && h[9:0] != 10'd0;
  endfunction

  function automatic bit half_inf(logic [15:0] h);
    return h[14:10] == 5'd31 && h[9:0] == 10'd0;
  endfunction

  // significand and exponent of the lsb: value = sig * 2^lsb_exp
  function automatic logic [63:0] half_sig(logic [15:0] h);
    return 64'({h[14:10] != 5'd0, h[9:0]});
  endfunction

  function automatic int half_lsb_exp(logic [15:0] h);
    return ((h[14:10] == 5'd0) ? 1 : int'(h[14:10])) - 25;
  endfunction

  // round sgn * mag * 2^ex to nearest even binary16
  function automatic logic [15:0] round_to_half(bit sgn, logic [63:0] mag, int ex);
    int p, ue, lsb, sh, o;
    logic [63:0] q, rem, hw;
    p = 0;
    q = 64'd0;
    if (mag == 64'd0) return {sgn, 15'd0};
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) p = i;
    end
    ue = p + ex;
    lsb = (ue >= -14) ? ue - 10 : -24;
    sh = lsb - ex;
    if (sh <= 0) begin
      q = mag << (-sh);
    end else if (sh < 64) begin
      q = mag >> sh;
      rem = mag & ((64'd1 << sh) - 64'd1);
      hw = 64'd1 << (sh - 1);
      if (rem > hw || (rem == hw && q[0])) q = q + 64'd1;
    end
    // hidden bit in q carries the biased exponent up by one
    if (ue > 15) o = 32'h7C00;
    else o = ((ue >= -14) ? ((ue + 14) << 10) : 0) + int'(q[15:0]);
    if (o >= 32'h7C00) o = 32'h7C00;
    return {sgn, o[14:0]};
  endfunction

  function automatic logic [15:0] half_product(logic [15:0] x, logic [15:0] y);
    bit s;
    s = x[15] ^ y[15];
    if (half_nan(x) || half_nan(y) || (half_inf(x) && y[14:0] == 15'd0) ||
        (half_inf(y) && x[14:0] == 15'd0)) return HALF_QNAN;
    if (half_inf(x) || half_inf(y)) return {s, HALF_INF};
    return round_to_half(s, half_sig(x) * half_sig(y), half_lsb_exp(x) + half_lsb_exp(y));
  endfunction

  function automatic logic [15:0] half_sum(logic [15:0] x, logic [15:0] y);
    int ex, ey, e;
    longint tx, ty, t;
    if (half_nan(x) || half_nan(y) || (half_inf(x) && half_inf(y) && x[15] != y[15]))
      return HALF_QNAN;
    if (half_inf(x)) return x;
    if (half_inf(y)) return y;
    ex = half_lsb_exp(x);
    ey = half_lsb_exp(y);
    e = (ex < ey) ? ex : ey;
    tx = longint'(half_sig(x) << (ex - e));
    ty = longint'(half_sig(y) << (ey - e));
    if (x[15]) tx = -tx;
    if (y[15]) ty = -ty;
    t = tx + ty;
    // exact cancellation is +0 unless both addends are negative
    if (t == 0) return {x[15] & y[15], 15'd0};
    if (t < 0) return round_to_half(1'b1, 64'(-t), e);
    return round_to_half(1'b0, 64'(t), e);
  endfunction

  function automatic bit dim_valid(logic [4:0] d);
    return d >= 5'd1 && d <= 5'd16;
  endfunction

  // expected answer for one transaction, store writes applied to the shadow
  function automatic out_t matmul_answer(in_t it);
    out_t r;
    logic [15:0] acc;
    r.result_value = 16'd0;
    r.status = ST_OK;
    if (it.mode == MODE_WR_A) begin
      a_elems[it.row_index * DIM + it.col_index] = it.element_value;
    end else if (it.mode == MODE_WR_B) begin
      b_elems[it.row_index * DIM + it.col_index] = it.element_value;
    end else if (it.mode == MODE_COMP) begin
      if (a_cols_q != b_rows_q) begin
        r.status = ST_SHAPE;
      end else if (!dim_valid(a_rows_q) || !dim_valid(a_cols_q) || !dim_valid(b_cols_q) ||
                   it.row_index >= a_rows_q || it.col_index >= b_cols_q) begin
        r.status = ST_RANGE;
      end else begin
        // inner products summed in order of rising k
        acc = half_product(a_elems[it.row_index * DIM], b_elems[it.col_index]);
        for (int k = 1; k < a_cols_q; k++) begin
          acc = half_sum(acc, half_product(a_elems[it.row_index * DIM + k],
                                           b_elems[k * DIM + it.col_index]));
        end
        r.result_value = acc;
      end
    end else begin
      r.status = ST_RANGE;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------
  // send one transaction; valid stays up into the next send when no gap is drawn
  task automatic send_item(in_t it, bit typed, out_t want);
    out_t model_out;
    while (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    model_out = matmul_answer(it);
    c_elems_due.push_back(typed ? want : model_out);
    items_sent++;
  endtask

  // dimension registers change only once every pending result is back
  task automatic set_dims(logic [4:0] ar, logic [4:0] ac, logic [4:0] br, logic [4:0] bc);
    in_valid <= 1'b0;
    while (c_elems_due.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_A_ROWS; cfg_data <= ar; @(posedge clk);
    cfg_index <= CFG_A_COLS; cfg_data <= ac; @(posedge clk);
    cfg_index <= CFG_B_ROWS; cfg_data <= br; @(posedge clk);
    cfg_index <= CFG_B_COLS; cfg_data <= bc; @(posedge clk);
    cfg_we <= 1'b0;
    a_rows_q = ar;
    a_cols_q = ac;
    b_rows_q = br;
    b_cols_q = bc;
  endtask

  function automatic logic [15:0] pick_half();
    logic [15:0] specials [11] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00,
                                   16'h7C01, 16'h0001, 16'h8001, 16'h03FF, 16'h7BFF,
                                   16'h0400};
    case ($urandom_range(9))
      0: return specials[$urandom_range(10)];
      1: return 16'($urandom);
      default: return {1'($urandom), 5'($urandom_range(17, 12)), 10'($urandom)};
    endcase
  endfunction

  function automatic in_t make_item(logic [1:0] m, int r, int c, logic [15:0] v);
    in_t it;
    it.mode = m;
    it.row_index = 4'(r);
    it.col_index = 4'(c);
    it.element_value = v;
    return it;
  endfunction

  // directed table: dimension change or transaction, typed answer where obvious
  typedef struct {
    bit is_cfg;
    logic [4:0] ar, ac, br, bc;
    in_t it;
    bit typed;
    out_t want;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic void plan_dims(int ar, int ac, int br, int bc);
    plan_row_t p;
    p = '{default: '0};
    p.is_cfg = 1'b1;
    p.ar = 5'(ar); p.ac = 5'(ac); p.br = 5'(br); p.bc = 5'(bc);
    plan.push_back(p);
  endfunction

  function automatic void plan_item(in_t it, bit typed, logic [15:0] v, logic [1:0] st);
    plan_row_t p;
    p = '{default: '0};
    p.it = it;
    p.typed = typed;
    p.want.result_value = v;
    p.want.status = st;
    plan.push_back(p);
  endfunction

  initial begin
    int phase_len, r, row_cap, col_cap;
    logic [4:0] ar, ac, br, bc;
    in_t it;
    out_t none;
    none = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // preload every element so no compute ever reads an unwritten entry
    for (int i = 0; i < DIM * DIM; i++) begin
      send_item(make_item(MODE_WR_A, i / DIM, i % DIM, pick_half()), 1'b0, none);
      send_item(make_item(MODE_WR_B, i / DIM, i % DIM, pick_half()), 1'b0, none);
    end

    // full size from reset, corners of the result
    plan_item(make_item(MODE_COMP, 0, 0, 16'hFFFF), 1'b0, 16'd0, ST_OK);
    plan_item(make_item(MODE_COMP, 15, 15, 16'h0000), 1'b0, 16'd0, ST_OK);
    plan_item(make_item(MODE_UNUSED, 15, 15, 16'hFFFF), 1'b1, 16'd0, ST_RANGE);
    // inner dimensions disagree: shape error wins over everything
    plan_dims(16, 3, 16, 16);
    plan_item(make_item(MODE_COMP, 0, 0, 16'd0), 1'b1, 16'd0, ST_SHAPE);
    plan_dims(0, 1, 1, 1);
    plan_item(make_item(MODE_COMP, 0, 0, 16'd0), 1'b1, 16'd0, ST_RANGE);
    plan_dims(2, 17, 17, 31);
    plan_item(make_item(MODE_COMP, 0, 0, 16'd0), 1'b1, 16'd0, ST_RANGE);
    // matrix-vector shape, requests outside it and one inside
    plan_dims(2, 16, 16, 1);
    plan_item(make_item(MODE_COMP, 5, 0, 16'd0), 1'b1, 16'd0, ST_RANGE);
    plan_item(make_item(MODE_COMP, 1, 1, 16'd0), 1'b1, 16'd0, ST_RANGE);
    plan_item(make_item(MODE_COMP, 1, 0, 16'd0), 1'b0, 16'd0, ST_OK);
    // single-term dot products on special operands
    plan_dims(1, 1, 1, 1);
    plan_item(make_item(MODE_WR_A, 0, 0, 16'h7C00), 1'b1, 16'd0, ST_OK);
    plan_item(make_item(MODE_WR_B, 0, 0, 16'h0000), 1'b1, 16'd0, ST_OK);
    plan_item(make_item(MODE_COMP, 0, 0, 16'd0), 1'b1, HALF_QNAN, ST_OK);
    plan_item(make_item(MODE_WR_B, 0, 0, 16'h3C00), 1'b1, 16'd0, ST_OK);
    plan_item(make_item(MODE_COMP, 0, 0, 16'd0), 1'b1, 16'h7C00, ST_OK);
    plan_item(make_item(MODE_WR_A, 0, 0, 16'h7BFF), 1'b1, 16'd0, ST_OK);
    plan_item(make_item(MODE_WR_B, 0, 0, 16'h7BFF), 1'b1, 16'd0, ST_OK);
    plan_item(make_item(MODE_COMP, 0, 0, 16'd0), 1'b1, 16'h7C00, ST_OK);
    plan_item(make_item(MODE_WR_A, 0, 0, 16'h8001), 1'b1, 16'd0, ST_OK);
    plan_item(make_item(MODE_WR_B, 0, 0, 16'h0001), 1'b1, 16'd0, ST_OK);
    plan_item(make_item(MODE_COMP, 0, 0, 16'd0), 1'b1, 16'h8000, ST_OK);
    plan_item(make_item(MODE_WR_A, 0, 0, 16'h7E00), 1'b1, 16'd0, ST_OK);
    plan_item(make_item(MODE_COMP, 0, 0, 16'd0), 1'b1, HALF_QNAN, ST_OK);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_dims(plan[i].ar, plan[i].ac, plan[i].br, plan[i].bc);
      else send_item(plan[i].it, plan[i].typed, plan[i].want);
    end

    // random phases, each under one set of dimensions
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(9);
      ac = 5'($urandom_range(16, 1));
      ar = 5'($urandom_range(16, 1));
      bc = 5'($urandom_range(16, 1));
      br = ac;
      case (r)
        0: begin ar = 5'd16; ac = 5'd16; br = 5'd16; bc = 5'd16; end
        1: begin ar = 5'd1; ac = 5'd1; br = 5'd1; bc = 5'd1; end
        2: br = 5'($urandom_range(31));
        3: begin
          ar = ($urandom_range(1)) ? 5'd0 : 5'($urandom_range(31, 17));
          bc = ($urandom_range(1)) ? bc : 5'($urandom_range(31, 17));
        end
        default: ;
      endcase
      set_dims(ar, ac, br, bc);
      // one stretch with neither side holding back
      quiet = (items_sent > 900 && items_sent < 1050);
      row_cap = dim_valid(ar) ? int'(ar) - 1 : 15;
      col_cap = dim_valid(bc) ? int'(bc) - 1 : 15;
      phase_len = $urandom_range(60, 30);
      for (int n = 0; n < phase_len; n++) begin
        r = $urandom_range(99);
        if (r < 35) begin
          it = make_item(($urandom_range(1)) ? MODE_WR_B : MODE_WR_A, $urandom_range(15),
                         $urandom_range(15), pick_half());
        end else if (r < 85) begin
          it = make_item(MODE_COMP, $urandom_range(row_cap), $urandom_range(col_cap),
                         16'($urandom));
        end else if (r < 95) begin
          it = make_item(MODE_COMP, $urandom_range(15), $urandom_range(15), 16'($urandom));
        end else begin
          it = make_item(MODE_UNUSED, $urandom_range(15), $urandom_range(15), 16'($urandom));
        end
        send_item(it, 1'b0, none);
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // drain, then a little extra time for stray results
    while (c_elems_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // ---------------------------------------------------------------
  // result side: random backpressure and the scoreboard
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 17);
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (c_elems_due.size() == 0) begin
        fails++;
        $display("%0t: result with nothing pending, got value %h status %0d",
                 $time, out_data.result_value, out_data.status);
      end else begin
        want = c_elems_due.pop_front();
        if (out_data.result_value !== want.result_value) begin
          fails++;
          $display("%0t: result_value expected %h actual %h",
                   $time, want.result_value, out_data.result_value);
        end
        if (out_data.status !== want.status) begin
          fails++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_data.status);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
`default_nettype wire
